FILE: rtl/compound_name_canonicalizer_unit_macros.svh
// Assertion macros shared by the canonicalizer RTL.
`ifndef COMPOUND_NAME_CANONICALIZER_UNIT_MACROS_SVH
`define COMPOUND_NAME_CANONICALIZER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CCN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("canonicalizer assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CCN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("canonicalizer assertion failed");

`endif

FILE: rtl/ccn_pkg.sv
// Types, codes and character helpers for the compound name canonicalizer.
package ccn_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_START       = 3'd0;
  localparam logic [2:0] PH_NAME_ENDED  = 3'd1;
  localparam logic [2:0] PH_INDEX       = 3'd2;
  localparam logic [2:0] PH_INDEX_CLOSE = 3'd3;
  localparam logic [2:0] PH_INDEX_ENDED = 3'd4;

  // Result kind codes
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  // Characters of the grammar
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CASE_OFS  = 8'h20;

  typedef struct packed {
    logic [2:0] phase;
    logic       in_token;
    logic       at_first;
    logic       draining;
  } ccn_state_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] ch;
    logic [1:0] kind;
  } ccn_result_t;

  localparam ccn_state_t STATE_RESET = '{
    phase: PH_START, in_token: 1'b0, at_first: 1'b1, draining: 1'b0
  };

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return c >= 8'h41 && c <= 8'h5A;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return is_upper(c) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_token_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_DASH || c == CH_CARET;
  endfunction

  // Lower case outside an index body; map dash and caret to underscore
  function automatic logic [7:0] canon_char(input logic [7:0] c, input logic [2:0] ph);
    logic [7:0] r;
    r = c;
    if (ph != PH_INDEX_CLOSE && is_upper(c)) begin
      r = c + CASE_OFS;
    end else if (c == CH_DASH || c == CH_CARET) begin
      r = CH_UNDER;
    end
    return r;
  endfunction

endpackage

FILE: rtl/compound_name_canonicalizer_unit.sv
// Compound name canonicalizer: input register, step logic, result register.
// A character accepted into the input register writes any result to the output
// register when it advances, which waits while a held result is not taken.
// Unstalled, one character per cycle; the parse state loop is one step deep.
// Reset (rst, synchronous): empties both registers, parse state to name start.
`include "compound_name_canonicalizer_unit_macros.svh"

module compound_name_canonicalizer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       is_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic [1:0] kind
);
  import ccn_pkg::*;

  logic        in_full;
  logic [7:0]  char_q;
  logic        end_q;
  ccn_state_t  st;
  ccn_state_t  st_next;
  ccn_result_t res;
  logic        advance;

  // Move the held transaction through the step when the result slot frees
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  ccn_step u_step (
    .st      (st),
    .c       (char_q),
    .is_end  (end_q),
    .st_next (st_next),
    .res     (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_q <= in_char;
      end_q  <= is_end;
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_char <= res.ch;
      kind     <= res.kind;
    end
  end

  // Status results carry no character
  `CCN_ASSERT_NOW(a_status_char_zero, out_valid && kind != KIND_CHAR, out_char == 8'h00)
  // While draining, only the terminator may produce a result
  `CCN_ASSERT_NOW(a_drain_silent, advance && st.draining && !end_q, !res.emit)
  // The terminator returns the parser to its reset state
  `CCN_ASSERT_NEXT(a_end_resets, advance && end_q, st == STATE_RESET)
  // Never take a new transaction while the held one is blocked
  `CCN_ASSERT_NOW(a_no_overrun, in_ready, !(in_full && out_valid && !out_ready))

endmodule

FILE: rtl/ccn_step.sv
// Next-state and result logic for one character of the compound name.
module ccn_step (
  input  ccn_pkg::ccn_state_t  st,
  input  logic [7:0]           c,
  input  logic                 is_end,
  output ccn_pkg::ccn_state_t  st_next,
  output ccn_pkg::ccn_result_t res
);
  import ccn_pkg::*;

  always_comb begin
    st_next  = st;
    res.emit = 1'b0;
    res.ch   = 8'h00;
    res.kind = KIND_CHAR;

    priority if (is_end) begin
      // Terminator: report status unless already reported, then reset
      if (!st.draining) begin
        res.emit = 1'b1;
        res.kind = (st.phase == PH_NAME_ENDED || st.phase == PH_INDEX_ENDED) ?
                   KIND_DONE : KIND_BAD;
      end
      st_next = STATE_RESET;
    end else if (st.draining) begin
      // Drop bytes until the terminator
    end else if (st.at_first && is_ws(c)) begin
      // Skip leading white space
    end else if (st.at_first && c == CH_DOT) begin
      // Leading dot: emit it, a name must still follow
      st_next.at_first = 1'b0;
      res.emit = 1'b1;
      res.ch   = CH_DOT;
    end else if (st.in_token && is_token_char(c)) begin
      // Continue the current token
      st_next.at_first = 1'b0;
      res.emit = 1'b1;
      res.ch   = canon_char(c, st.phase);
    end else if (is_ws(c)) begin
      // White space ends any token
      st_next.at_first = 1'b0;
      st_next.in_token = 1'b0;
    end else begin
      st_next.at_first = 1'b0;
      st_next.in_token = 1'b0;
      res.emit = 1'b1;
      unique case (st.phase)
        PH_START: begin
          if (is_alpha(c)) begin
            st_next.phase    = PH_NAME_ENDED;
            st_next.in_token = 1'b1;
            res.ch           = canon_char(c, PH_NAME_ENDED);
          end else begin
            st_next.draining = 1'b1;
            res.kind         = KIND_BAD;
          end
        end
        PH_NAME_ENDED: begin
          if (c == CH_LBRACK) begin
            st_next.phase = PH_INDEX;
            res.ch        = c;
          end else if (c == CH_DOT) begin
            st_next.phase = PH_START;
            res.ch        = c;
          end else begin
            st_next.draining = 1'b1;
            res.kind         = KIND_DONE;
          end
        end
        PH_INDEX: begin
          if (is_alpha(c) || is_digit(c)) begin
            st_next.phase    = PH_INDEX_CLOSE;
            st_next.in_token = 1'b1;
            res.ch           = canon_char(c, PH_INDEX_CLOSE);
          end else if (c == CH_DOLLAR) begin
            st_next.phase = PH_INDEX_CLOSE;
            res.ch        = c;
          end else if (c == CH_RBRACK) begin
            st_next.phase = PH_INDEX_ENDED;
            res.ch        = c;
          end else begin
            st_next.draining = 1'b1;
            res.kind         = KIND_BAD;
          end
        end
        PH_INDEX_CLOSE: begin
          if (c == CH_RBRACK) begin
            st_next.phase = PH_INDEX_ENDED;
            res.ch        = c;
          end else begin
            st_next.draining = 1'b1;
            res.kind         = KIND_BAD;
          end
        end
        PH_INDEX_ENDED: begin
          if (c == CH_DOT) begin
            st_next.phase = PH_START;
            res.ch        = c;
          end else begin
            st_next.draining = 1'b1;
            res.kind         = KIND_DONE;
          end
        end
        default: begin
          st_next.draining = 1'b1;
          res.kind         = KIND_BAD;
        end
      endcase
    end
  end

endmodule
